>>> src/markov_transition_counter_core_defines.svh
// Assertion macros shared by the markov transition counter RTL
`ifndef MARKOV_TRANSITION_COUNTER_CORE_DEFINES_SVH
`define MARKOV_TRANSITION_COUNTER_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define MTC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define MTC_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define MTC_ASSERT(lbl, prop)
`define MTC_ASSERT_RST(lbl, prop)
`endif
`endif

>>> src/mtc_pkg.sv
// Types and constants of the markov transition counter
package mtc_pkg;
  localparam int MAX_STATES   = 16;
  localparam int SIDX_W       = $clog2(MAX_STATES);
  localparam int KNOWN_W      = SIDX_W + 1;
  localparam int MAX_ENTITIES = 64;
  localparam int EIDX_W       = $clog2(MAX_ENTITIES);
  localparam int ECNT_W       = EIDX_W + 1;
  localparam int COUNT_BITS   = 32;
  localparam int CADDR_W      = 2 * SIDX_W;
  localparam int NUM_W        = COUNT_BITS + 9;
  localparam int SUM_W        = NUM_W + SIDX_W;
  localparam int Q_W          = 17;
  localparam int PROB_W       = 16;
  localparam int ALPHA_W      = 16;
  localparam int KEY_W        = 32;
  localparam int CODE_W       = 64;
  localparam int ADDR_W       = 3;
  localparam int DATA_W       = 32;

  typedef enum logic [1:0] {
    ERR_OK          = 2'd0,
    ERR_STATE_FULL  = 2'd1,
    ERR_ENTITY_FULL = 2'd2,
    ERR_BAD_ROW     = 2'd3
  } err_t;

  typedef enum logic [0:0] {
    REG_ALPHA = 1'b0,
    REG_UDE   = 1'b1
  } reg_idx_t;

  localparam logic KIND_OBSERVE = 1'b0;

  typedef struct packed {
    logic              kind;
    logic [KEY_W-1:0]  entity_key;
    logic [CODE_W-1:0] state_code;
    logic [SIDX_W-1:0] row_index;
  } item_t;

  typedef struct packed {
    logic [SIDX_W-1:0] state_index;
    logic              new_entity;
    logic [SIDX_W-1:0] column_index;
    logic [CODE_W-1:0] column_code;
    logic [PROB_W-1:0] probability;
    logic [1:0]        error_code;
    logic              last;
  } result_t;

  typedef struct packed {
    logic [ALPHA_W-1:0] alpha;
    logic               uniform_dead_end;
  } cfg_t;
endpackage

>>> src/mtc_regs.sv
// APB configuration registers of the markov transition counter
module mtc_regs import mtc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);
  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[2]);
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.alpha            <= '0;
      cfg.uniform_dead_end <= 1'b1;
    end else if (wr) begin
      unique case (idx)
        REG_ALPHA: cfg.alpha            <= pwdata[ALPHA_W-1:0];
        REG_UDE:   cfg.uniform_dead_end <= pwdata[0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ALPHA: prdata = {{(DATA_W-ALPHA_W){1'b0}}, cfg.alpha};
      REG_UDE:   prdata = {{(DATA_W-1){1'b0}}, cfg.uniform_dead_end};
      default:   prdata = '0;
    endcase
  end
endmodule

>>> src/mtc_div.sv
// Shared restoring divider: floor(num * 65536 / den), one quotient bit per cycle
module mtc_div import mtc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SUM_W-1:0] num,
  input  logic [SUM_W-1:0] den,
  output logic             done,
  output logic [Q_W-1:0]   q
);
  logic             busy;
  logic [4:0]       step;
  logic [SUM_W-1:0] r;
  logic [SUM_W-1:0] d;
  logic [SUM_W:0]   cand;
  logic             ge;

  assign cand = (step == 5'd0) ? {1'b0, r} : {r, 1'b0};
  assign ge   = cand >= {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 5'd1;
        if (step == 5'(Q_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      r <= num;
      d <= den;
      q <= '0;
    end else if (busy) begin
      r <= ge ? SUM_W'(cand - {1'b0, d}) : cand[SUM_W-1:0];
      q <= {q[Q_W-2:0], ge};
    end
  end
endmodule

>>> src/markov_transition_counter_core.sv
// Markov transition counter top level: sequencer, tables and output register
//
// Usage: items come in on item/item_valid/item_stall, results leave on
// result/result_valid/result_stall; a transfer takes place when valid is
// high and stall is low. Configuration is written over the APB port
// (smoothing_alpha at 0x0, uniform_dead_end at 0x4) while the block is idle.
// One item is worked at a time; item_stall is low only while idle.
// An observe scans the state table up to the match (every known state for a
// new code) and the entity table up to the match (all 64 slots for a new
// key), then, unless a table is full, updates the tables and, for a known
// key, its transition count, and loads the result.
// A query first sums its row, then per column runs the shared bit-serial
// divider (skipped when the row sum is zero and uniform_dead_end is low),
// one result per known column. A bad row gives a single error result.
// After reset the count table is cleared in one pass over its 256 entries,
// during which no item is taken; configuration writes are taken at any time.
// A stalled receiver holds the output register; the next item may already
// be taken while a result waits, and work pauses only when a new result
// has to be loaded.
`include "markov_transition_counter_core_defines.svh"
module markov_transition_counter_core import mtc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  item_t             item,
  output logic              result_valid,
  input  logic              result_stall,
  output result_t           result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);
  typedef enum logic [11:0] {
    S_CLEAR  = 12'b000000000001,
    S_IDLE   = 12'b000000000010,
    S_SSCAN  = 12'b000000000100,
    S_ESCAN  = 12'b000000001000,
    S_DECIDE = 12'b000000010000,
    S_CRD    = 12'b000000100000,
    S_CWR    = 12'b000001000000,
    S_EMIT   = 12'b000010000000,
    S_QSUM   = 12'b000100000000,
    S_QDIV   = 12'b001000000000,
    S_QWAIT  = 12'b010000000000,
    S_QEMIT  = 12'b100000000000
  } state_t;

  state_t             state;
  cfg_t               cfg;
  item_t              cur;
  result_t            res;
  logic [KNOWN_W-1:0] known;
  logic [KNOWN_W-1:0] scnt;
  logic [ECNT_W-1:0]  ecnt;
  logic [CADDR_W-1:0] clr;
  logic               ph;
  logic               found;
  logic               free_found;
  logic [EIDX_W-1:0]  eidx;
  logic [EIDX_W-1:0]  free_idx;
  logic [SIDX_W-1:0]  sidx;
  logic [SIDX_W-1:0]  prev;
  logic               new_state;
  logic [SUM_W-1:0]   sum;
  logic [CODE_W-1:0]  code_hold;

  logic [CODE_W-1:0]     sc_mem [MAX_STATES];
  logic [CODE_W-1:0]     sc_rd;
  logic [KEY_W-1:0]      key_mem [MAX_ENTITIES];
  logic [KEY_W-1:0]      key_rd;
  logic [SIDX_W-1:0]     last_mem [MAX_ENTITIES];
  logic [SIDX_W-1:0]     last_rd;
  logic [COUNT_BITS-1:0] cnt_mem [MAX_STATES*MAX_STATES];
  logic [COUNT_BITS-1:0] cnt_rd;
  logic [MAX_ENTITIES-1:0] valid;

  logic               out_free;
  logic               load;
  logic               ok;
  logic               sc_we;
  logic               ent_we;
  logic [EIDX_W-1:0]  ent_waddr;
  logic               cnt_we;
  logic [CADDR_W-1:0] cnt_waddr;
  logic [COUNT_BITS-1:0] cnt_wdata;
  logic [CADDR_W-1:0] cnt_raddr;
  logic [NUM_W-1:0]   numer;
  logic               div_start;
  logic [SUM_W-1:0]   div_num;
  logic [SUM_W-1:0]   div_den;
  logic               div_done;
  logic [Q_W-1:0]     div_q;
  logic [PROB_W-1:0]  prob_sat;
  logic [EIDX_W-1:0]  eaddr;

  function automatic result_t single_result(err_t err, logic [SIDX_W-1:0] si, logic ne);
    result_t r;
    r             = '0;
    r.state_index = si;
    r.new_entity  = ne;
    r.error_code  = err;
    r.last        = 1'b1;
    return r;
  endfunction

  function automatic result_t column_result(logic [SIDX_W-1:0] col,
                                            logic [CODE_W-1:0] code, logic is_last);
    result_t r;
    r              = '0;
    r.column_index = col;
    r.column_code  = code;
    r.error_code   = ERR_OK;
    r.last         = is_last;
    return r;
  endfunction

  mtc_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  mtc_div u_div (
    .clk, .rst, .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .q(div_q)
  );

  assign item_stall = (state != S_IDLE);
  assign out_free   = !result_valid || !result_stall;
  assign load       = ((state == S_EMIT) || (state == S_QEMIT)) && out_free;
  assign eaddr      = ecnt[EIDX_W-1:0];
  assign ok = !(new_state && (known == KNOWN_W'(MAX_STATES))) && (found || free_found);
  assign sc_we     = (state == S_DECIDE) && ok && new_state;
  assign ent_we    = (state == S_DECIDE) && ok;
  assign ent_waddr = found ? eidx : free_idx;
  assign cnt_raddr = (state == S_CRD) ? {prev, sidx} : {cur.row_index, scnt[SIDX_W-1:0]};
  assign cnt_we    = (state == S_CLEAR) || (state == S_CWR);
  assign cnt_waddr = (state == S_CLEAR) ? clr : {prev, sidx};
  assign cnt_wdata = (state == S_CLEAR) ? '0 :
                     ((&cnt_rd) ? cnt_rd : cnt_rd + COUNT_BITS'(1));
  assign numer     = {1'b0, cnt_rd, 8'd0} + NUM_W'(cfg.alpha);
  assign div_start = (state == S_QDIV) && ph && (sum != '0 || cfg.uniform_dead_end);
  assign div_num   = (sum == '0) ? SUM_W'(1) : SUM_W'(numer);
  assign div_den   = (sum == '0) ? SUM_W'(known) : sum;
  assign prob_sat  = div_q[Q_W-1] ? '1 : div_q[PROB_W-1:0];

  always_ff @(posedge clk) begin
    if (sc_we) sc_mem[known[SIDX_W-1:0]] <= cur.state_code;
    sc_rd <= sc_mem[scnt[SIDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      key_mem[ent_waddr]  <= cur.entity_key;
      last_mem[ent_waddr] <= sidx;
    end
    key_rd  <= key_mem[eaddr];
    last_rd <= last_mem[eaddr];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
    cnt_rd <= cnt_mem[cnt_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (ent_we) begin
      valid[ent_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr          <= '0;
      known        <= '0;
      ph           <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr <= clr + CADDR_W'(1);
          if (&clr) state <= S_IDLE;
        end
        S_IDLE: begin
          if (item_valid) begin
            cur        <= item;
            scnt       <= '0;
            ecnt       <= '0;
            ph         <= 1'b0;
            found      <= 1'b0;
            free_found <= 1'b0;
            sum        <= '0;
            if (item.kind == KIND_OBSERVE) begin
              state <= S_SSCAN;
            end else if (known == '0 || KNOWN_W'(item.row_index) >= known) begin
              res   <= single_result(ERR_BAD_ROW, '0, 1'b0);
              state <= S_EMIT;
            end else begin
              state <= S_QSUM;
            end
          end
        end
        S_SSCAN: begin
          if (!ph) begin
            if (scnt == known) begin
              sidx      <= known[SIDX_W-1:0];
              new_state <= 1'b1;
              state     <= S_ESCAN;
            end else begin
              ph <= 1'b1;
            end
          end else begin
            ph <= 1'b0;
            if (sc_rd == cur.state_code) begin
              sidx      <= scnt[SIDX_W-1:0];
              new_state <= 1'b0;
              state     <= S_ESCAN;
            end else begin
              scnt <= scnt + KNOWN_W'(1);
            end
          end
        end
        S_ESCAN: begin
          if (!ph) begin
            if (ecnt == ECNT_W'(MAX_ENTITIES)) state <= S_DECIDE;
            else ph <= 1'b1;
          end else begin
            ph   <= 1'b0;
            ecnt <= ecnt + ECNT_W'(1);
            if (valid[eaddr]) begin
              if (key_rd == cur.entity_key) begin
                found <= 1'b1;
                eidx  <= eaddr;
                prev  <= last_rd;
                state <= S_DECIDE;
              end
            end else if (!free_found) begin
              free_found <= 1'b1;
              free_idx   <= eaddr;
            end
          end
        end
        S_DECIDE: begin
          if (new_state && known == KNOWN_W'(MAX_STATES)) begin
            res   <= single_result(ERR_STATE_FULL, '0, 1'b0);
            state <= S_EMIT;
          end else if (!found && !free_found) begin
            res   <= single_result(ERR_ENTITY_FULL, '0, 1'b0);
            state <= S_EMIT;
          end else begin
            if (new_state) known <= known + KNOWN_W'(1);
            res   <= single_result(ERR_OK, sidx, !found);
            state <= found ? S_CRD : S_EMIT;
          end
        end
        S_CRD: state <= S_CWR;
        S_CWR: state <= S_EMIT;
        S_EMIT: begin
          if (out_free) begin
            result <= res;
            state  <= S_IDLE;
          end
        end
        S_QSUM: begin
          if (!ph) begin
            if (scnt == known) begin
              scnt  <= '0;
              state <= S_QDIV;
            end else begin
              ph <= 1'b1;
            end
          end else begin
            ph   <= 1'b0;
            sum  <= sum + SUM_W'(numer);
            scnt <= scnt + KNOWN_W'(1);
          end
        end
        S_QDIV: begin
          if (!ph) begin
            ph <= 1'b1;
          end else begin
            ph        <= 1'b0;
            code_hold <= sc_rd;
            res       <= column_result(scnt[SIDX_W-1:0], sc_rd,
                                       (scnt + KNOWN_W'(1) == known));
            state     <= div_start ? S_QWAIT : S_QEMIT;
          end
        end
        S_QWAIT: begin
          if (div_done) begin
            res.probability <= prob_sat;
            state <= S_QEMIT;
          end
        end
        S_QEMIT: begin
          if (out_free) begin
            result <= res;
            scnt   <= scnt + KNOWN_W'(1);
            state  <= res.last ? S_IDLE : S_QDIV;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `MTC_ASSERT(a_known_range, known <= KNOWN_W'(MAX_STATES))
  `MTC_ASSERT(a_div_only_wait, div_done |-> state == S_QWAIT)
  `MTC_ASSERT_RST(a_reset_clear, $past(rst) |-> state == S_CLEAR)
  `MTC_ASSERT(a_query_col_code, (state == S_QEMIT) |-> res.column_code == code_hold)
endmodule

>>> test/markov_transition_counter_checker.sv
// Checker for the markov transition counter: watches both channels and the APB port
module markov_transition_counter_checker import mtc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic              item_stall,
  input  item_t             item,
  input  logic              result_valid,
  input  logic              result_stall,
  input  result_t           result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output int                errors,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [ALPHA_W-1:0] alpha;
  logic               dead_end_uniform;
  logic [CODE_W-1:0]  codes [MAX_STATES];
  int                 n_states;
  logic [KEY_W-1:0]   keys [MAX_ENTITIES];
  logic               key_used [MAX_ENTITIES];
  int                 key_state [MAX_ENTITIES];
  logic [COUNT_BITS-1:0] counts [MAX_STATES][MAX_STATES];
  result_t            expected_results [$];

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch in %s: got %0h, expected %0h", what, got, want);
    errors++;
  endtask

  function automatic result_t blank_result();
    result_t r;
    r = '0;
    r.error_code = ERR_OK;
    r.last = 1'b1;
    return r;
  endfunction

  task automatic count_transition(item_t it);
    int s_idx, e_idx, free_idx;
    result_t r;
    r = blank_result();
    s_idx = n_states;
    e_idx = -1;
    free_idx = -1;
    for (int s = 0; s < n_states; s++)
      if (codes[s] == it.state_code && s_idx == n_states) s_idx = s;
    for (int e = 0; e < MAX_ENTITIES; e++) begin
      if (key_used[e]) begin
        if (keys[e] == it.entity_key && e_idx < 0) e_idx = e;
      end else if (free_idx < 0) begin
        free_idx = e;
      end
    end
    if (s_idx == n_states && n_states >= MAX_STATES) begin
      r.error_code = ERR_STATE_FULL;
    end else if (e_idx < 0 && free_idx < 0) begin
      r.error_code = ERR_ENTITY_FULL;
    end else begin
      if (s_idx == n_states) begin
        codes[s_idx] = it.state_code;
        n_states++;
      end
      if (e_idx < 0) begin
        e_idx = free_idx;
        key_used[e_idx] = 1'b1;
        keys[e_idx] = it.entity_key;
        r.new_entity = 1'b1;
      end else if (counts[key_state[e_idx]][s_idx] != '1) begin
        counts[key_state[e_idx]][s_idx]++;
      end
      key_state[e_idx] = s_idx;
      r.state_index = SIDX_W'(s_idx);
    end
    expected_results = {expected_results, r};
  endtask

  task automatic emit_row(item_t it);
    logic [63:0] row_sum, num, q;
    result_t r;
    if (n_states == 0 || int'(it.row_index) >= n_states) begin
      r = blank_result();
      r.error_code = ERR_BAD_ROW;
      expected_results = {expected_results, r};
    end else begin
      row_sum = 0;
      for (int j = 0; j < n_states; j++)
        row_sum += {counts[it.row_index][j], 8'h00} + alpha;
      for (int j = 0; j < n_states; j++) begin
        r = blank_result();
        if (row_sum == 0) begin
          q = dead_end_uniform ? 64'd65536 / n_states : 0;
        end else begin
          num = {counts[it.row_index][j], 8'h00} + alpha;
          q = (num << 16) / row_sum;
        end
        r.probability = (q > 65535) ? 16'hFFFF : q[15:0];
        r.column_index = SIDX_W'(j);
        r.column_code = codes[j];
        r.last = (j == n_states - 1);
        expected_results = {expected_results, r};
      end
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      alpha = '0;
      dead_end_uniform = 1'b1;
      n_states = 0;
      errors = 0;
      expected_results.delete();
      for (int e = 0; e < MAX_ENTITIES; e++) key_used[e] = 1'b0;
      for (int a = 0; a < MAX_STATES; a++)
        for (int b = 0; b < MAX_STATES; b++) counts[a][b] = '0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[2]))
          REG_ALPHA: alpha = pwdata[ALPHA_W-1:0];
          REG_UDE:   dead_end_uniform = pwdata[0];
        endcase
      end
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          $display("unexpected result transfer: %h", result);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (result.state_index != want.state_index)
            report("state_index", result.state_index, want.state_index);
          if (result.new_entity != want.new_entity)
            report("new_entity", result.new_entity, want.new_entity);
          if (result.column_index != want.column_index)
            report("column_index", result.column_index, want.column_index);
          if (result.column_code != want.column_code)
            report("column_code", result.column_code, want.column_code);
          if (result.probability != want.probability)
            report("probability", result.probability, want.probability);
          if (result.error_code != want.error_code)
            report("error_code", result.error_code, want.error_code);
          if (result.last != want.last)
            report("last", result.last, want.last);
        end
      end
      if (item_valid && !item_stall) begin
        if (item.kind == KIND_OBSERVE) count_transition(item);
        else emit_row(item);
      end
    end
    pending = expected_results.size();
  end
endmodule

>>> test/testbench.sv
// Testbench top for the markov transition counter: stimulus, idling and verdict
module testbench;
  import mtc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic KIND_QUERY = ~KIND_OBSERVE;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_ITEMS = 360;
  localparam int N_PHASES = 6;
  localparam int HOLD_CYCLES = 500;

  logic              clk;
  logic              rst;
  logic              item_valid;
  logic              item_stall;
  item_t             item;
  logic              result_valid;
  logic              result_stall;
  result_t           result;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  int                errors;
  int                pending;
  int                send_idle_pct;
  int                recv_idle_pct;
  int                hold_requests;
  int                cycles = 0;
  logic [CODE_W-1:0] code_pool [MAX_STATES];
  logic [KEY_W-1:0]  key_pool [MAX_ENTITIES];

  markov_transition_counter_core dut (.*);

  markov_transition_counter_checker checker_i (
    .clk, .rst, .item_valid, .item_stall, .item, .result_valid, .result_stall,
    .result, .psel, .penable, .pwrite, .pready, .paddr, .pwdata, .errors, .pending
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver: random stall, with a long hold-off on request
  initial begin
    int hold_left;
    int holds_done;
    hold_left = 0;
    holds_done = 0;
    result_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && holds_done != hold_requests) begin
        holds_done = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  task automatic send(item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
  endtask

  task automatic apb_write(reg_idx_t idx, logic [DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(idx) << 2;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_config(logic [ALPHA_W-1:0] a, logic ude);
    drain();
    apb_write(REG_ALPHA, a);
    apb_write(REG_UDE, ude);
  endtask

  function automatic item_t observe(logic [KEY_W-1:0] k, logic [CODE_W-1:0] c);
    item_t it;
    it = '0;
    it.kind = KIND_OBSERVE;
    it.entity_key = k;
    it.state_code = c;
    it.row_index = SIDX_W'($urandom);
    return it;
  endfunction

  function automatic item_t query(logic [SIDX_W-1:0] row);
    item_t it;
    it = '0;
    it.kind = KIND_QUERY;
    it.entity_key = $urandom;
    it.state_code = {$urandom, $urandom};
    it.row_index = row;
    return it;
  endfunction

  function automatic item_t random_item();
    logic [KEY_W-1:0]  k;
    logic [CODE_W-1:0] c;
    if ($urandom_range(99) < 30) return query(SIDX_W'($urandom));
    k = ($urandom_range(99) < 85) ? key_pool[EIDX_W'($urandom_range(MAX_ENTITIES-1))]
                                  : $urandom;
    c = ($urandom_range(99) < 80) ? code_pool[SIDX_W'($urandom_range(MAX_STATES-1))]
                                  : {$urandom, $urandom};
    return observe(k, c);
  endfunction

  initial begin
    logic [ALPHA_W-1:0] alphas [N_PHASES];
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_requests = 0;
    for (int i = 0; i < MAX_STATES; i++) code_pool[i] = {$urandom, $urandom};
    for (int i = 0; i < MAX_ENTITIES; i++) key_pool[i] = $urandom;
    code_pool[0] = '0;
    code_pool[1] = '1;
    key_pool[0] = '0;
    key_pool[1] = '1;
    alphas = '{16'h0000, 16'hFFFF, 16'h0100, 16'h0001, 16'h0000, 16'h0000};
    alphas[3] = ALPHA_W'($urandom);
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: empty table, dead ends, extremes
    apb_write(REG_ALPHA, 0);
    apb_write(REG_UDE, 1);
    send(query(0));
    send(observe(key_pool[0], code_pool[0]));
    send(observe(key_pool[0], code_pool[1]));
    send(observe(key_pool[1], "ABCDEFGH"));
    send(observe(key_pool[1], code_pool[1]));
    send(observe(key_pool[0], code_pool[1]));
    send(observe(key_pool[0], code_pool[0]));
    send(query(0));
    send(query(1));
    send(query(2));
    send(query(3));
    send(query(15));
    set_config(0, 1'b0);
    send(query(1));
    send(query(2));
    send(query(0));
    set_config(16'hFFFF, 1'b1);
    send(query(0));
    send(query(2));
    send(observe(key_pool[1], code_pool[0]));
    send(query(1));

    for (int p = 0; p < N_PHASES; p++) begin
      set_config(alphas[p], p[0]);
      case (p / 2)
        0: begin send_idle_pct = 21; recv_idle_pct = 85; end
        1: begin send_idle_pct = 85; recv_idle_pct = 21; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      if (p == 4) hold_requests <= hold_requests + 1;
      for (int i = 0; i < RANDOM_ITEMS / N_PHASES; i++) send(random_item());
    end

    drain();
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

>>> markov_transition_counter_core.f
+incdir+src
src/mtc_pkg.sv
src/mtc_regs.sv
src/mtc_div.sv
src/markov_transition_counter_core.sv
test/markov_transition_counter_checker.sv
test/testbench.sv
